[design/ple_pkg.sv]
// ----------------------------------------------------------------------------
// Positional list engine package
// Shared widths, operation and status codes, and the cell command set.
// ----------------------------------------------------------------------------
`default_nettype none

package ple_pkg;

  // Fixed field widths of the request and response items.
  localparam int unsigned OP_W      = 3;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned POS_W     = 7;
  localparam int unsigned STAT_W    = 2;
  localparam int unsigned CNT_OUT_W = 7;

  // Defaults for the top-level parameters.
  localparam int unsigned DEF_CAPACITY   = 64;
  localparam int unsigned DEF_DATA_WIDTH = 32;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_REMOVE = 3'd1,
    OP_READ   = 3'd2,
    OP_FIND   = 3'd3,
    OP_SORTED = 3'd4,
    OP_CLEAR  = 3'd5
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_EXEC   = 2'd1,
    S_REDUCE = 2'd2
  } state_e;

  // What every cell of the row does in the execute cycle.
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2,
    CELL_PROBE  = 2'd3
  } cell_cmd_e;

  // Per-cell probe results, registered inside the cell.
  typedef struct packed {
    logic hit;
    logic order_bad;
  } cell_flags_t;

endpackage

`default_nettype wire

[design/ple_stream_if.sv]
// ----------------------------------------------------------------------------
// Positional list engine channels
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface ple_req_if;
  logic                               valid;
  logic                               ready;
  logic        [ple_pkg::OP_W-1:0]    op;
  logic signed [ple_pkg::VAL_W-1:0]   value;
  logic        [ple_pkg::POS_W-1:0]   position;

  modport source (output valid, output op, output value, output position, input ready);
  modport sink   (input valid, input op, input value, input position, output ready);
endinterface

interface ple_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic        [ple_pkg::STAT_W-1:0]    status;
  logic signed [ple_pkg::VAL_W-1:0]     data;
  logic                                 flag;
  logic        [ple_pkg::CNT_OUT_W-1:0] count;
  logic                                 empty_res;

  modport source (output valid, output status, output data, output flag, output count,
                  output empty_res, input ready);
  modport sink   (input valid, input status, input data, input flag, input count,
                  input empty_res, output ready);
endinterface

`default_nettype wire

[design/ple_cell.sv]
// ----------------------------------------------------------------------------
// Positional list engine cell
// Holds one list entry, shifts it to or from its neighbors, and probes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_cell #(
  parameter int unsigned DATA_WIDTH = ple_pkg::DEF_DATA_WIDTH,
  parameter int unsigned CNT_W      = $clog2(ple_pkg::DEF_CAPACITY + 1),
  parameter int unsigned INDEX      = 0
) (
  input  wire logic                      clk_i,
  input  wire ple_pkg::cell_cmd_e        cmd_i,
  input  wire logic [CNT_W-1:0]          tgt_i,
  input  wire logic [CNT_W-1:0]          len_i,
  input  wire logic [DATA_WIDTH-1:0]     value_i,
  input  wire logic [DATA_WIDTH-1:0]     left_i,
  input  wire logic [DATA_WIDTH-1:0]     right_i,
  output      logic [DATA_WIDTH-1:0]     data_o,
  output      ple_pkg::cell_flags_t      flags_o,
  output      logic [DATA_WIDTH-1:0]     rd_o
);

  localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

  logic [DATA_WIDTH-1:0] data_d, data_q;
  logic [DATA_WIDTH-1:0] rd_d, rd_q;
  ple_pkg::cell_flags_t  flags_d, flags_q;
  logic                  live;

  always_comb begin
    data_d = data_q;
    case (cmd_i)
      ple_pkg::CELL_INSERT: begin
        // The target takes the new value; everything behind it moves up one.
        if (IDX == tgt_i) begin
          data_d = value_i;
        end else if (IDX > tgt_i) begin
          data_d = left_i;
        end
      end
      ple_pkg::CELL_REMOVE: begin
        if (IDX >= tgt_i) begin
          data_d = right_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    live              = IDX < len_i;
    flags_d.hit       = live && (data_q == value_i);
    flags_d.order_bad = (INDEX != 0) && live && ($signed(left_i) > $signed(data_q));
    rd_d              = (IDX == tgt_i) ? data_q : '0;
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    if (cmd_i == ple_pkg::CELL_PROBE) begin
      flags_q <= flags_d;
      rd_q    <= rd_d;
    end
  end

  assign data_o  = data_q;
  assign flags_o = flags_q;
  assign rd_o    = rd_q;

endmodule

`default_nettype wire

[design/positional_list_engine.sv]
// ----------------------------------------------------------------------------
// Positional list engine
// Ordered list of signed values kept in a row of cells, one entry per cell.
// ----------------------------------------------------------------------------
// The engine keeps up to CAPACITY signed entries in list order and serves one
// request per item: insert at a 1-based position, remove or read at a
// position, find a value, check that the list is non-decreasing, or clear.
// Every entry lives in its own cell; an insert or remove shifts all cells
// behind the target by one place at once, and a probe compares all cells
// against the request at once. Once an item is accepted, the execute state
// updates and probes the cells, then the reduce state reduces the probe bits
// into the output register when that register is free. The next item is taken
// in the same cycle the reduction loads the output register. The result waits
// in that register, so a stalled consumer holds the engine only after the
// next item has also finished. A bad position gives status 1 and an insert at
// a valid position on a full list gives status 2; both leave the list
// untouched. Opcodes 6 and 7 are accepted and answered with an ok status and
// no change. There is no clearing pass after reset: only entries below the
// count are ever looked at.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_engine #(
  parameter int unsigned CAPACITY   = ple_pkg::DEF_CAPACITY,
  parameter int unsigned DATA_WIDTH = ple_pkg::DEF_DATA_WIDTH
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ple_req_if.sink    req_i,
  ple_rsp_if.source  rsp_o
);

  // Width of the entry count, and a compare width that holds position and
  // count plus one without overflow.
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = ((CNT_W > ple_pkg::POS_W) ? CNT_W : ple_pkg::POS_W) + 1;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // Control state.
  ple_pkg::state_e  state_d, state_q;
  logic [CNT_W-1:0] length_d, length_q;
  logic             out_valid_d, out_valid_q;

  // Request held for the execute cycle.
  logic [ple_pkg::OP_W-1:0]  cmd_op_q;
  logic [DATA_WIDTH-1:0]     cmd_value_q;
  logic [ple_pkg::POS_W-1:0] cmd_pos_q;

  // Execute results held for the reduction cycle.
  logic [ple_pkg::OP_W-1:0]   res_op_q;
  ple_pkg::status_e           res_status_q, status;
  logic                       res_rd_ok_q;

  // Output register.
  logic [ple_pkg::STAT_W-1:0]    out_status_q;
  logic [ple_pkg::VAL_W-1:0]     out_data_q, out_data_d;
  logic                          out_flag_q, out_flag_d;

  // Handshake and cell control.
  logic               in_accept;
  logic               in_ready;
  logic               out_load;
  ple_pkg::cell_cmd_e cell_cmd;

  // Position checks.
  logic [CMP_W-1:0] pos_w, len_w, tgt_w;
  logic [CNT_W-1:0] tgt;
  logic             ins_ok, rm_ok, full;

  // Cell row.
  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
  logic [DATA_WIDTH-1:0] cell_rd   [CAPACITY];
  ple_pkg::cell_flags_t  cell_flags[CAPACITY];
  logic [CAPACITY-1:0]   hit_vec, bad_vec;
  logic [DATA_WIDTH-1:0] rd_any;

  // --------------------------------------------------------------------------
  // Position and capacity checks on the held request. The list is 1-based, so
  // the cell index is the position minus one.
  // --------------------------------------------------------------------------
  always_comb begin
    pos_w  = CMP_W'(cmd_pos_q);
    len_w  = CMP_W'(length_q);
    tgt_w  = pos_w - CMP_W'(1);
    tgt    = tgt_w[CNT_W-1:0];
    ins_ok = (pos_w != '0) && (pos_w <= len_w + CMP_W'(1));
    rm_ok  = (pos_w != '0) && (pos_w <= len_w);
    full   = length_q == CAP_CNT;
  end

  // Status and new count of the request in the execute cycle.
  always_comb begin
    status   = ple_pkg::ST_OK;
    length_d = length_q;
    case (cmd_op_q)
      ple_pkg::OP_INSERT: begin
        if (!ins_ok) begin
          status = ple_pkg::ST_BAD_POS;
        end else if (full) begin
          status = ple_pkg::ST_FULL;
        end else begin
          length_d = length_q + CNT_W'(1);
        end
      end
      ple_pkg::OP_REMOVE: begin
        if (!rm_ok) begin
          status = ple_pkg::ST_BAD_POS;
        end else begin
          length_d = length_q - CNT_W'(1);
        end
      end
      ple_pkg::OP_READ: begin
        if (!rm_ok) begin
          status = ple_pkg::ST_BAD_POS;
        end
      end
      ple_pkg::OP_CLEAR: begin
        length_d = '0;
      end
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: idle, execute in the cells, reduce the probe bits.
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ple_pkg::S_IDLE: begin
        if (in_accept) begin
          state_d = ple_pkg::S_EXEC;
        end
      end
      ple_pkg::S_EXEC: begin
        state_d = ple_pkg::S_REDUCE;
      end
      ple_pkg::S_REDUCE: begin
        if (out_load) begin
          state_d = in_accept ? ple_pkg::S_EXEC : ple_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = ple_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_load = (state_q == ple_pkg::S_REDUCE) && (!out_valid_q || rsp_o.ready);
    in_ready = (state_q == ple_pkg::S_IDLE) || out_load;
    cell_cmd = ple_pkg::CELL_HOLD;
    if (state_q == ple_pkg::S_EXEC) begin
      case (cmd_op_q)
        ple_pkg::OP_INSERT: begin
          cell_cmd = (ins_ok && !full) ? ple_pkg::CELL_INSERT : ple_pkg::CELL_HOLD;
        end
        ple_pkg::OP_REMOVE: begin
          cell_cmd = rm_ok ? ple_pkg::CELL_REMOVE : ple_pkg::CELL_HOLD;
        end
        ple_pkg::OP_READ, ple_pkg::OP_FIND, ple_pkg::OP_SORTED: begin
          cell_cmd = ple_pkg::CELL_PROBE;
        end
        default: begin
          cell_cmd = ple_pkg::CELL_HOLD;
        end
      endcase
    end
  end

  assign in_accept = req_i.valid && in_ready;
  assign req_i.ready = in_ready;

  // --------------------------------------------------------------------------
  // Row of cells. Each cell sees its left and right neighbor; the ends see
  // themselves, which is harmless since those values are never kept in use.
  // --------------------------------------------------------------------------
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    localparam int unsigned LEFT  = (g == 0) ? 0 : g - 1;
    localparam int unsigned RIGHT = (g == CAPACITY - 1) ? g : g + 1;

    ple_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .CNT_W      (CNT_W),
      .INDEX      (g)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cell_cmd),
      .tgt_i   (tgt),
      .len_i   (length_q),
      .value_i (cmd_value_q),
      .left_i  (cell_data[LEFT]),
      .right_i (cell_data[RIGHT]),
      .data_o  (cell_data[g]),
      .flags_o (cell_flags[g]),
      .rd_o    (cell_rd[g])
    );

    assign hit_vec[g] = cell_flags[g].hit;
    assign bad_vec[g] = cell_flags[g].order_bad;
  end

  // Only the target cell returns a nonzero read word, so an OR merges them.
  always_comb begin
    rd_any = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_any = rd_any | cell_rd[i];
    end
  end

  // Result of the reduction cycle.
  always_comb begin
    out_data_d = '0;
    out_flag_d = 1'b0;
    case (res_op_q)
      ple_pkg::OP_READ: begin
        out_data_d = res_rd_ok_q ? ple_pkg::VAL_W'(rd_any) : '0;
      end
      ple_pkg::OP_FIND: begin
        out_flag_d = |hit_vec;
      end
      ple_pkg::OP_SORTED: begin
        out_flag_d = ~(|bad_vec);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ple_pkg::S_IDLE;
      length_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (state_q == ple_pkg::S_EXEC) begin
        length_q <= length_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_op_q    <= req_i.op;
      cmd_value_q <= DATA_WIDTH'(req_i.value);
      cmd_pos_q   <= req_i.position;
    end
    if (state_q == ple_pkg::S_EXEC) begin
      res_op_q     <= cmd_op_q;
      res_status_q <= status;
      res_rd_ok_q  <= rm_ok;
    end
    if (out_load) begin
      out_status_q <= res_status_q;
      out_data_q   <= out_data_d;
      out_flag_q   <= out_flag_d;
    end
  end

  // The count is taken from the live register: it is the post-request value
  // while the result is shown, since no later request has executed yet.
  logic [CNT_W-1:0] out_count_q;

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_count_q <= length_q;
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.status    = out_status_q;
  assign rsp_o.data      = out_data_q;
  assign rsp_o.flag      = out_flag_q;
  assign rsp_o.count     = ple_pkg::CNT_OUT_W'(out_count_q);
  assign rsp_o.empty_res = out_count_q == '0;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  a_length_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    length_q <= CAP_CNT)
    else $error("entry count above capacity");

  a_error_keeps_list : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ple_pkg::S_EXEC) && (status != ple_pkg::ST_OK) |=> $stable(length_q))
    else $error("rejected request changed the entry count");

  a_result_from_reduce : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ple_pkg::S_REDUCE))
    else $error("result appeared outside the reduction cycle");

endmodule

`default_nettype wire
